// ===== src/fwkh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fwkh_pkg;

   // Sizes of the parsed structure
   localparam int KEY_HASH_BYTES   = 32;
   localparam int MIN_HEADER_BYTES = 32;
   localparam int SHORT_LIMIT      = 32;

   // Result queue between parser and output stage
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register reset values
   localparam logic [31:0] IMAGE_MAGIC_RESET    = 32'h96F3_B83D;
   localparam logic [15:0] TLV_INFO_MAGIC_RESET = 16'h6907;
   localparam logic [15:0] KEYHASH_TYPE_RESET   = 16'h0001;

   // Result kinds
   localparam logic KIND_KEY     = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      CSR_IMAGE_MAGIC    = 2'd0,
      CSR_TLV_INFO_MAGIC = 2'd1,
      CSR_KEYHASH_TYPE   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_FOUND      = 3'd0,
      ST_NO_KEY     = 3'd1,
      ST_SHORT      = 3'd2,
      ST_MAGIC      = 3'd3,
      ST_HDR_SIZE   = 3'd4,
      ST_TRUNCATED  = 3'd5,
      ST_INFO_MAGIC = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_HDR    = 3'd0,
      PH_SKIP   = 3'd1,
      PH_INFO   = 3'd2,
      PH_TLVHDR = 3'd3,
      PH_BODY   = 3'd4,
      PH_STOP   = 3'd5,
      PH_FAIL   = 3'd6
   } phase_type;

   // One queue entry: results caused by one image byte
   typedef struct packed {
      logic       key_valid;
      logic [7:0] key_byte;
      logic [4:0] key_index;
      logic       verdict_valid;
      status_type status;
   } rsp_entry_type;

endpackage

`default_nettype wire

// ===== src/fwkh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fwkh_front import fwkh_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_en,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata,
   input  wire logic          accept,
   input  wire logic [7:0]    data_byte,
   input  wire logic          last_byte,
   output rsp_entry_type      entry,
   output logic               push
);

   logic [31:0] image_magic_ff;
   logic [15:0] tlv_info_magic_ff;
   logic [15:0] keyhash_type_ff;

   logic [32:0] pos_ff, pos_in;
   logic [31:0] magic_ff, magic_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [31:0] img_ff, img_in;
   logic [32:0] info_ff, info_in;
   status_type  fail_ff, fail_in;     // ST_FOUND here means no failure yet
   phase_type   phase_ff, phase_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] bl_ff, bl_in;
   logic        key_done_ff, key_done_in;

   phase_type   eff_phase;
   logic [31:0] magic_new;
   logic [15:0] hdr_new;
   logic [31:0] img_new;
   logic [15:0] type_hi;
   logic [15:0] len_hi;
   logic        hdr_bad;
   logic        is_key;
   logic [15:0] bl_dec;
   logic        emit_key;
   status_type  verdict;

   // Little-endian fields shift in from the top
   assign magic_new = {data_byte, magic_ff[31:8]};
   assign img_new   = {data_byte, img_ff[31:8]};
   assign hdr_new   = {data_byte, hdr_ff[7:0]};
   assign type_hi   = {data_byte, type_ff[7:0]};
   assign len_hi    = {data_byte, len_ff[7:0]};
   assign hdr_bad   = (hdr_new < 16'(MIN_HEADER_BYTES)) || (hdr_new[1:0] != 2'b00);
   assign bl_dec    = bl_ff - 16'd1;
   assign is_key    = !key_done_ff && (type_ff == keyhash_type_ff)
                      && (len_ff == 16'(KEY_HASH_BYTES));

   // Skip phase falls into the info record on the byte at the info offset
   assign eff_phase = (phase_ff == PH_SKIP && pos_ff == info_ff) ? PH_INFO : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_magic_ff    <= IMAGE_MAGIC_RESET;
         tlv_info_magic_ff <= TLV_INFO_MAGIC_RESET;
         keyhash_type_ff   <= KEYHASH_TYPE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_MAGIC:    image_magic_ff    <= csr_wdata;
            CSR_TLV_INFO_MAGIC: tlv_info_magic_ff <= csr_wdata[15:0];
            CSR_KEYHASH_TYPE:   keyhash_type_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (eff_phase)
         PH_HDR: begin
            if (pos_ff == 33'd3 && magic_new != image_magic_ff) begin
               phase_in = PH_FAIL;
            end else if (pos_ff == 33'd9 && hdr_bad) begin
               phase_in = PH_FAIL;
            end else if (pos_ff == 33'd15) begin
               phase_in = PH_SKIP;
            end
         end
         PH_INFO: begin
            if (bl_ff[1:0] == 2'd3) begin
               phase_in = (fail_ff != ST_FOUND) ? PH_FAIL : PH_TLVHDR;
            end else begin
               phase_in = PH_INFO;
            end
         end
         PH_TLVHDR: begin
            if (bl_ff[1:0] == 2'd3) begin
               phase_in = (type_ff == 16'd0 || len_hi == 16'd0) ? PH_STOP : PH_BODY;
            end
         end
         PH_BODY: begin
            if (bl_dec == 16'd0) begin
               phase_in = is_key ? PH_STOP : PH_TLVHDR;
            end
         end
         default: ;
      endcase
   end

   // Field capture and key emission
   always_comb begin
      pos_in      = (&pos_ff) ? pos_ff : pos_ff + 33'd1;
      magic_in    = magic_ff;
      hdr_in      = hdr_ff;
      img_in      = img_ff;
      info_in     = info_ff;
      fail_in     = fail_ff;
      type_in     = type_ff;
      len_in      = len_ff;
      bl_in       = bl_ff;
      key_done_in = key_done_ff;
      emit_key    = 1'b0;
      case (eff_phase)
         PH_HDR: begin
            if (pos_ff[32:2] == 31'd0) begin
               magic_in = magic_new;
               if (pos_ff[1:0] == 2'd3 && magic_new != image_magic_ff) begin
                  fail_in = ST_MAGIC;
               end
            end else if (pos_ff == 33'd8) begin
               hdr_in = {8'd0, data_byte};
            end else if (pos_ff == 33'd9) begin
               hdr_in = hdr_new;
               if (hdr_bad) begin
                  fail_in = ST_HDR_SIZE;
               end
            end else if (pos_ff >= 33'd12 && pos_ff <= 33'd15) begin
               img_in = img_new;
               if (pos_ff == 33'd15) begin
                  info_in = 33'(hdr_ff) + 33'(img_new);
               end
            end
         end
         PH_INFO: begin
            // bl counts the info record bytes here
            if (bl_ff[1:0] == 2'd3) begin
               type_in = 16'd0;
               bl_in   = 16'd0;
            end else begin
               bl_in = bl_ff + 16'd1;
               if (bl_ff[1:0] == 2'd0) begin
                  type_in = {8'd0, data_byte};
               end else if (bl_ff[1:0] == 2'd1) begin
                  type_in = type_hi;
                  if (type_hi != tlv_info_magic_ff) begin
                     fail_in = ST_INFO_MAGIC;
                  end
               end
            end
         end
         PH_TLVHDR: begin
            case (bl_ff[1:0])
               2'd0:    type_in = {8'd0, data_byte};
               2'd1:    type_in = type_hi;
               2'd2:    len_in  = {8'd0, data_byte};
               default: len_in  = len_hi;
            endcase
            if (bl_ff[1:0] != 2'd3) begin
               bl_in = bl_ff + 16'd1;
            end else if (type_ff != 16'd0 && len_hi != 16'd0) begin
               bl_in = len_hi;
            end
         end
         PH_BODY: begin
            bl_in    = bl_dec;
            emit_key = is_key;
            if (bl_dec == 16'd0 && is_key) begin
               key_done_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Verdict, from the state after this byte
   always_comb begin
      if (pos_ff < 33'(SHORT_LIMIT - 1)) begin
         verdict = ST_SHORT;
      end else if (fail_in == ST_MAGIC || fail_in == ST_HDR_SIZE) begin
         verdict = fail_in;
      end else if (phase_in inside {PH_HDR, PH_SKIP, PH_INFO}) begin
         verdict = ST_TRUNCATED;
      end else if (fail_in == ST_INFO_MAGIC) begin
         verdict = ST_INFO_MAGIC;
      end else begin
         verdict = key_done_in ? ST_FOUND : ST_NO_KEY;
      end
   end

   assign entry.key_valid     = emit_key;
   assign entry.key_byte      = data_byte;
   assign entry.key_index     = len_ff[4:0] - bl_ff[4:0];
   assign entry.verdict_valid = last_byte;
   assign entry.status        = verdict;
   assign push                = accept && (emit_key || last_byte);

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff      <= '0;
         magic_ff    <= '0;
         hdr_ff      <= '0;
         img_ff      <= '0;
         info_ff     <= '0;
         fail_ff     <= ST_FOUND;
         phase_ff    <= PH_HDR;
         type_ff     <= '0;
         len_ff      <= '0;
         bl_ff       <= '0;
         key_done_ff <= 1'b0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         magic_ff    <= magic_in;
         hdr_ff      <= hdr_in;
         img_ff      <= img_in;
         info_ff     <= info_in;
         fail_ff     <= fail_in;
         phase_ff    <= phase_in;
         type_ff     <= type_in;
         len_ff      <= len_in;
         bl_ff       <= bl_in;
         key_done_ff <= key_done_in;
      end
   end

   a_emit_in_body: assert property (@(posedge clock) disable iff (reset)
      emit_key |-> phase_ff == PH_BODY)
      else $error("key byte emitted outside a TLV body");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> pos_ff == 33'd0 && phase_ff == PH_HDR && !key_done_ff)
      else $error("parser state not cleared after final byte");

endmodule

`default_nettype wire

// ===== src/fwkh_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fwkh_queue import fwkh_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_entry_type push_entry,
   input  wire logic          pop,
   output rsp_entry_type      head,
   output logic               head_valid,
   output logic               full
);

   rsp_entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff;
   logic [QUEUE_COUNT_W-1:0]     count_ff;

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QUEUE_COUNT_W'(1);
            2'b01:   count_ff <= count_ff - QUEUE_COUNT_W'(1);
            default: ;
         endcase
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop) && !(pop && !head_valid))
      else $error("result queue overrun or underrun");

endmodule

`default_nettype wire

// ===== src/fwkh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fwkh_back import fwkh_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rsp_entry_type head,
   input  wire logic          head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_kind,
   output logic [7:0]         rsp_key_byte,
   output logic [4:0]         rsp_key_index,
   output logic               rsp_header_valid,
   output logic               rsp_key_found,
   output logic [2:0]         rsp_status,
   output logic               rsp_last_result
);

   rsp_entry_type hold_ff;
   logic          hold_valid_ff;
   logic          key_sent_ff;

   logic key_pending;
   logic beat;
   logic entry_done;

   assign key_pending = hold_ff.key_valid && !key_sent_ff;
   assign beat        = hold_valid_ff && !rsp_stall;
   assign entry_done  = beat && (!key_pending || !hold_ff.verdict_valid);
   assign pop         = head_valid && (!hold_valid_ff || entry_done);

   always_ff @(posedge clock) begin
      if (pop) begin
         hold_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         key_sent_ff   <= 1'b0;
      end else if (pop) begin
         hold_valid_ff <= 1'b1;
         key_sent_ff   <= 1'b0;
      end else if (entry_done) begin
         hold_valid_ff <= 1'b0;
      end else if (beat) begin
         // key beat left, verdict of the same byte still to go
         key_sent_ff <= 1'b1;
      end
   end

   assign rsp_valid        = hold_valid_ff;
   assign rsp_kind         = key_pending ? KIND_KEY : KIND_VERDICT;
   assign rsp_key_byte     = key_pending ? hold_ff.key_byte : 8'd0;
   assign rsp_key_index    = key_pending ? hold_ff.key_index : 5'd0;
   assign rsp_header_valid = !key_pending
                             && (hold_ff.status == ST_FOUND || hold_ff.status == ST_NO_KEY);
   assign rsp_key_found    = !key_pending && (hold_ff.status == ST_FOUND);
   assign rsp_status       = key_pending ? ST_FOUND : hold_ff.status;
   assign rsp_last_result  = key_pending ? !hold_ff.verdict_valid : 1'b1;

   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      beat && key_pending && hold_ff.verdict_valid
      |=> rsp_valid && rsp_kind == KIND_VERDICT && rsp_last_result)
      else $error("verdict beat lost after key beat of final byte");

endmodule

`default_nettype wire

// ===== src/firmware_image_tlv_keyhash_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming key-hash extractor for a signed firmware image. Feed the image
// one byte per beat on req_, with req_last_byte on its final byte; the next
// beat starts a new image. The parser checks the little-endian magic at
// offset 0, the header size at offsets 8..9 (at least 32, multiple of 4),
// and the TLV info magic at header size + image size, then walks the TLV
// entries. Each body byte of the first key-hash entry (matching type,
// 32 bytes long) comes out as a key beat (rsp_kind 0) as it arrives; the
// final byte yields a verdict beat (rsp_kind 1) with header_valid,
// key_found and status. Key beats only count if the verdict says found.
// Rate: one byte per clock on req_ unless req_stall is high, and one result
// beat per clock on rsp_ unless rsp_stall is high; the byte-wise parser
// updates its counters on each accepted byte. A byte that is both the last
// key byte and the final image byte produces two beats. A four-entry result
// queue sits between parser and output register, so a stalled rsp_ holds off
// req_ only once that queue fills. Write csr_ registers (0: image magic,
// 1: TLV info magic, 2: key-hash TLV type) only while idle.

module firmware_image_tlv_keyhash_parser_core import fwkh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_key_byte,
   output logic [4:0]       rsp_key_index,
   output logic             rsp_header_valid,
   output logic             rsp_key_found,
   output logic [2:0]       rsp_status,
   output logic             rsp_last_result
);

   rsp_entry_type front_entry;
   rsp_entry_type head;
   logic          front_push;
   logic          head_valid;
   logic          queue_full;
   logic          pop;
   logic          req_accept;

   // Hold the input side only while the result queue is full
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   fwkh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (req_accept),
      .data_byte    (req_data_byte),
      .last_byte    (req_last_byte),
      .entry        (front_entry),
      .push         (front_push)
   );

   fwkh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   fwkh_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (head_valid),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_key_byte     (rsp_key_byte),
      .rsp_key_index    (rsp_key_index),
      .rsp_header_valid (rsp_header_valid),
      .rsp_key_found    (rsp_key_found),
      .rsp_status       (rsp_status),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

`default_nettype wire

// ===== sim/firmware_image_tlv_keyhash_parser_core_tb.sv =====
`timescale 1ns / 1ps

module firmware_image_tlv_keyhash_parser_core_tb;
   import fwkh_pkg::*;

   localparam int LONG_HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES    = 8;
   localparam int BYTES_PER_PHASE  = 300;
   localparam int NUM_PHASES       = 6;

   // One result beat as the block should present it
   typedef struct packed {
      logic       kind;
      logic [7:0] key_byte;
      logic [4:0] key_index;
      logic       header_valid;
      logic       key_found;
      logic [2:0] status;
      logic       last_result;
   } parse_beat_type;

   // Directed byte; verdicts are typed in where the status is obvious
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      bit         typed;
      status_type st;
   } directed_row_type;

   typedef enum int {
      SC_KEY, SC_KEY_AT_END, SC_NO_KEY, SC_ZERO_LEN, SC_WRONG_LEN, SC_KEY_CUT,
      SC_BAD_MAGIC, SC_BAD_HDR, SC_BAD_INFO, SC_TRUNC, SC_SHORT, SC_HUGE_OFFSET,
      SC_NOISE, SC_COUNT
   } image_case_type;

   // Short images only: everything here ends before 32 bytes
   localparam directed_row_type DIRECTED_ROWS [0:22] = '{
      '{8'h00, 1'b1, 1'b1, ST_SHORT},
      '{8'hFF, 1'b1, 1'b1, ST_SHORT},
      '{8'h3D, 1'b0, 1'b0, ST_FOUND},
      '{8'hB8, 1'b0, 1'b0, ST_FOUND},
      '{8'hF3, 1'b0, 1'b0, ST_FOUND},
      '{8'h96, 1'b0, 1'b0, ST_FOUND},
      '{8'h01, 1'b0, 1'b0, ST_FOUND},
      '{8'h02, 1'b0, 1'b0, ST_FOUND},
      '{8'h04, 1'b0, 1'b0, ST_FOUND},
      '{8'h08, 1'b0, 1'b0, ST_FOUND},
      '{8'h10, 1'b0, 1'b0, ST_FOUND},
      '{8'h20, 1'b0, 1'b0, ST_FOUND},
      '{8'h40, 1'b0, 1'b0, ST_FOUND},
      '{8'h80, 1'b0, 1'b0, ST_FOUND},
      '{8'hFE, 1'b0, 1'b0, ST_FOUND},
      '{8'hFD, 1'b0, 1'b0, ST_FOUND},
      '{8'hFB, 1'b0, 1'b0, ST_FOUND},
      '{8'hF7, 1'b0, 1'b0, ST_FOUND},
      '{8'hEF, 1'b0, 1'b0, ST_FOUND},
      '{8'hDF, 1'b0, 1'b0, ST_FOUND},
      '{8'hBF, 1'b0, 1'b0, ST_FOUND},
      '{8'h7F, 1'b1, 1'b1, ST_SHORT},
      '{8'hAA, 1'b1, 1'b1, ST_SHORT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_wdata = 32'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_key_byte;
   logic [4:0]  rsp_key_index;
   logic        rsp_header_valid;
   logic        rsp_key_found;
   logic [2:0]  rsp_status;
   logic        rsp_last_result;

   firmware_image_tlv_keyhash_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_key_byte     (rsp_key_byte),
      .rsp_key_index    (rsp_key_index),
      .rsp_header_valid (rsp_header_valid),
      .rsp_key_found    (rsp_key_found),
      .rsp_status       (rsp_status),
      .rsp_last_result  (rsp_last_result)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Register copies, kept in step with every csr write
   logic [31:0] cfg_image_magic = IMAGE_MAGIC_RESET;
   logic [15:0] cfg_info_magic  = TLV_INFO_MAGIC_RESET;
   logic [15:0] cfg_key_type    = KEYHASH_TYPE_RESET;

   // Parser state of the image in flight
   logic [32:0] img_pos      = '0;
   logic [31:0] magic_acc    = '0;
   logic [15:0] hdr_len      = '0;
   logic [31:0] img_len      = '0;
   logic [32:0] info_off     = '0;
   bit          img_failed   = 1'b0;
   status_type  fail_code    = ST_FOUND;
   phase_type   img_phase    = PH_HDR;
   logic [15:0] ent_type     = '0;
   logic [15:0] ent_len      = '0;
   logic [15:0] ent_left     = '0;
   bit          key_done     = 1'b0;

   parse_beat_type expected_beats[$];
   logic [7:0]     image_bytes[$];

   // Tag of the directed row currently on the bus
   bit          row_typed  = 1'b0;
   status_type  row_status = ST_FOUND;

   bit          no_idle = 1'b0;
   bit          long_hold_pending = 1'b0;

   int error_count   = 0;
   int bytes_sent    = 0;
   int images_sent   = 0;
   int settings_used = 1;
   int key_beats     = 0;
   int verdicts      = 0;
   logic [6:0] status_seen = '0;

   // Advance the parser by one accepted byte and queue the beats it causes.
   task automatic parse_image_byte(input logic [7:0] b, input logic last,
                                   input bit typed, input status_type typed_st);
      logic [32:0]    at;
      logic [32:0]    k;
      logic [1:0]     c;
      logic [15:0]    idx;
      bit             is_key;
      status_type     st;
      parse_beat_type beat;
      at     = img_pos;
      is_key = 1'b0;
      idx    = '0;
      if (img_phase == PH_SKIP && at == info_off) img_phase = PH_INFO;
      case (img_phase)
         PH_HDR: begin
            if (at < 4) begin
               magic_acc[8*at[1:0] +: 8] = b;
               if (at == 3 && magic_acc != cfg_image_magic) begin
                  img_failed = 1'b1;
                  fail_code  = ST_MAGIC;
                  img_phase  = PH_FAIL;
               end
            end else if (at == 8) begin
               hdr_len = {8'h00, b};
            end else if (at == 9) begin
               hdr_len[15:8] = b;
               if (hdr_len < MIN_HEADER_BYTES || hdr_len[1:0] != 2'b00) begin
                  img_failed = 1'b1;
                  fail_code  = ST_HDR_SIZE;
                  img_phase  = PH_FAIL;
               end
            end else if (at >= 12 && at <= 15) begin
               img_len[8*at[1:0] +: 8] = b;
               if (at == 15) begin
                  info_off  = {17'd0, hdr_len} + {1'b0, img_len};
                  img_phase = PH_SKIP;
               end
            end
         end
         PH_INFO: begin
            k = at - info_off;
            if (k == 0) begin
               ent_type = {8'h00, b};
            end else if (k == 1) begin
               ent_type[15:8] = b;
               if (ent_type != cfg_info_magic) begin
                  img_failed = 1'b1;
                  fail_code  = ST_INFO_MAGIC;
               end
            end else if (k >= 3) begin
               ent_type  = '0;
               ent_left  = '0;
               img_phase = img_failed ? PH_FAIL : PH_TLVHDR;
            end
         end
         PH_TLVHDR: begin
            c = ent_left[1:0];
            case (c)
               2'd0: ent_type = {8'h00, b};
               2'd1: ent_type[15:8] = b;
               2'd2: ent_len = {8'h00, b};
               default: ent_len[15:8] = b;
            endcase
            if (c != 2'd3) begin
               ent_left = 16'(c) + 16'd1;
            end else if (ent_type == 0 || ent_len == 0) begin
               img_phase = PH_STOP;
            end else begin
               ent_left  = ent_len;
               img_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            is_key = !key_done && ent_type == cfg_key_type && ent_len == KEY_HASH_BYTES;
            idx = ent_len - ent_left;
            ent_left = ent_left - 16'd1;
            if (ent_left == 0) begin
               if (is_key) begin
                  key_done  = 1'b1;
                  img_phase = PH_STOP;
               end else begin
                  img_phase = PH_TLVHDR;
               end
            end
         end
         default: ;
      endcase

      if (is_key) begin
         beat = '0;
         beat.kind        = KIND_KEY;
         beat.key_byte    = b;
         beat.key_index   = idx[4:0];
         beat.last_result = !last;
         expected_beats.push_back(beat);
      end
      if (img_pos != '1) img_pos = img_pos + 33'd1;

      if (last) begin
         // Verdict priority: short, magic or header size, truncated, info magic
         if (at < 33'(SHORT_LIMIT - 1)) st = ST_SHORT;
         else if (img_failed && (fail_code == ST_MAGIC || fail_code == ST_HDR_SIZE))
            st = fail_code;
         else if (img_phase <= PH_INFO) st = ST_TRUNCATED;
         else if (img_failed && fail_code == ST_INFO_MAGIC) st = ST_INFO_MAGIC;
         else st = key_done ? ST_FOUND : ST_NO_KEY;
         if (typed) st = typed_st;
         beat = '0;
         beat.kind         = KIND_VERDICT;
         beat.header_valid = (st == ST_FOUND || st == ST_NO_KEY);
         beat.key_found    = (st == ST_FOUND);
         beat.status       = st;
         beat.last_result  = 1'b1;
         expected_beats.push_back(beat);
         // Start over for the next image; registers stay
         img_pos    = '0;
         magic_acc  = '0;
         hdr_len    = '0;
         img_len    = '0;
         info_off   = '0;
         img_failed = 1'b0;
         fail_code  = ST_FOUND;
         img_phase  = PH_HDR;
         ent_type   = '0;
         ent_len    = '0;
         ent_left   = '0;
         key_done   = 1'b0;
      end
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // Predict on every accepted input beat, check every accepted result beat.
   always @(posedge clock) begin : scoreboard
      parse_beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            parse_image_byte(req_data_byte, req_last_byte, row_typed, row_status);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat, expected none, got kind %0d status %0d",
                        $time, rsp_kind, rsp_status);
            end else begin
               want = expected_beats.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("key_byte", want.key_byte, rsp_key_byte);
               check_field("key_index", want.key_index, rsp_key_index);
               check_field("header_valid", want.header_valid, rsp_header_valid);
               check_field("key_found", want.key_found, rsp_key_found);
               check_field("status", want.status, rsp_status);
               check_field("last_result", want.last_result, rsp_last_result);
            end
            if (rsp_kind == KIND_KEY) begin
               key_beats++;
            end else begin
               verdicts++;
               if (rsp_status <= ST_INFO_MAGIC) status_seen[rsp_status] = 1'b1;
            end
         end
      end
   end

   // Result side: stall a random number of cycles ahead of each beat, or
   // hold off for a long stretch when asked, so the internal queue fills.
   initial begin : result_sink
      int n;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] data, input logic last,
                            input bit typed, input status_type st);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      row_typed     <= typed;
      row_status    <= st;
      do @(posedge clock); while (!(req_valid && !req_stall));
      bytes_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every queued beat has come out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_IMAGE_MAGIC:    cfg_image_magic = value;
         CSR_TLV_INFO_MAGIC: cfg_info_magic  = value[15:0];
         CSR_KEYHASH_TYPE:   cfg_key_type    = value[15:0];
         default: ;
      endcase
   endtask

   // Upper bits of the 16-bit registers carry junk that must be dropped.
   task automatic apply_setting(input int phase);
      logic [15:0] junk;
      junk = 16'($urandom_range(0, 65535));
      case (phase)
         1: begin
            write_csr(CSR_IMAGE_MAGIC, 32'h0000_0000);
            write_csr(CSR_TLV_INFO_MAGIC, {junk, 16'h0000});
            write_csr(CSR_KEYHASH_TYPE, {junk, 16'h0000});
         end
         2: begin
            write_csr(CSR_IMAGE_MAGIC, 32'hFFFF_FFFF);
            write_csr(CSR_TLV_INFO_MAGIC, 32'hFFFF_FFFF);
            write_csr(CSR_KEYHASH_TYPE, 32'hFFFF_FFFF);
         end
         3: begin
            write_csr(CSR_IMAGE_MAGIC, $urandom);
            write_csr(CSR_TLV_INFO_MAGIC, $urandom);
            write_csr(CSR_KEYHASH_TYPE, {junk, 16'($urandom_range(1, 65535))});
         end
         4: begin
            write_csr(CSR_IMAGE_MAGIC, $urandom);
            write_csr(CSR_TLV_INFO_MAGIC, $urandom);
            write_csr(CSR_KEYHASH_TYPE, {junk, 16'h0001});
         end
         default: begin
            write_csr(CSR_IMAGE_MAGIC, IMAGE_MAGIC_RESET);
            write_csr(CSR_TLV_INFO_MAGIC, {16'h0000, TLV_INFO_MAGIC_RESET});
            write_csr(CSR_KEYHASH_TYPE, {16'h0000, KEYHASH_TYPE_RESET});
         end
      endcase
      settings_used++;
   endtask

   task automatic put_u16(input logic [15:0] v);
      image_bytes.push_back(v[7:0]);
      image_bytes.push_back(v[15:8]);
   endtask

   task automatic put_u32(input logic [31:0] v);
      put_u16(v[15:0]);
      put_u16(v[31:16]);
   endtask

   task automatic put_random(input int n);
      repeat (n) image_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Short entry that is never the key: its length is far from 32
   task automatic put_filler();
      int len;
      len = $urandom_range(1, 6);
      put_u16(16'($urandom_range(1, 65535)));
      put_u16(16'(len));
      put_random(len);
   endtask

   task automatic put_key_entry();
      put_u16(cfg_key_type);
      put_u16(16'(KEY_HASH_BYTES));
      put_random(KEY_HASH_BYTES);
   endtask

   // Build one image of the given flavor into image_bytes.
   task automatic build_image(input image_case_type sc);
      logic [31:0] magic;
      logic [15:0] hdr;
      logic [31:0] body_len;
      logic [15:0] info;
      int          cut;
      image_bytes.delete();
      if (sc == SC_NOISE) begin
         if ($urandom_range(0, 1)) put_u32(cfg_image_magic);
         put_random($urandom_range(1, 60));
         return;
      end
      magic    = cfg_image_magic;
      hdr      = 16'(MIN_HEADER_BYTES + 4 * $urandom_range(0, 2));
      body_len = $urandom_range(0, 6);
      info     = cfg_info_magic;
      case (sc)
         SC_BAD_MAGIC: magic = magic ^ (32'd1 << $urandom_range(0, 31));
         SC_BAD_HDR: begin
            case ($urandom_range(0, 2))
               0: hdr = 16'($urandom_range(0, MIN_HEADER_BYTES - 1));
               1: hdr = 16'hFFFF;
               default: hdr = 16'(MIN_HEADER_BYTES + 4 * $urandom_range(0, 8)
                                  + $urandom_range(1, 3));
            endcase
         end
         SC_BAD_INFO: info = info ^ (16'd1 << $urandom_range(0, 15));
         SC_HUGE_OFFSET: begin
            // Info record lies far beyond the end: always cut short
            hdr      = 16'hFFFC;
            body_len = 32'hFFFF_FFFF;
         end
         default: ;
      endcase
      put_u32(magic);
      put_random(4);
      put_u16(hdr);
      put_random(2);
      put_u32(body_len);
      if (sc == SC_BAD_MAGIC || sc == SC_BAD_HDR || sc == SC_HUGE_OFFSET) begin
         put_random($urandom_range(16, 40));
         return;
      end
      put_random(int'(hdr) + int'(body_len) - 16);
      put_u16(info);
      put_random(2);
      repeat ($urandom_range(0, 2)) put_filler();
      case (sc)
         SC_NO_KEY: begin
            put_u16(16'h0000);
            put_random($urandom_range(2, 8));
         end
         SC_ZERO_LEN: begin
            put_u16(16'($urandom_range(1, 65535)));
            put_u16(16'h0000);
            put_random($urandom_range(0, 8));
         end
         SC_WRONG_LEN: begin
            // Key type at the wrong length: skip its body, keep walking
            put_u16(cfg_key_type);
            cut = ($urandom_range(0, 1)) ? KEY_HASH_BYTES + 1 : $urandom_range(1, 31);
            put_u16(16'(cut));
            put_random(cut);
            if ($urandom_range(0, 1)) put_key_entry();
            put_random($urandom_range(0, 4));
         end
         SC_KEY_CUT: begin
            put_u16(cfg_key_type);
            put_u16(16'(KEY_HASH_BYTES));
            put_random($urandom_range(1, KEY_HASH_BYTES - 1));
         end
         SC_KEY_AT_END: put_key_entry();
         default: begin
            put_key_entry();
            // Anything after a complete key is ignored, a second key too
            if ($urandom_range(0, 1)) put_key_entry();
            if ($urandom_range(0, 1)) put_filler();
            put_random($urandom_range(0, 6));
         end
      endcase
      if (sc == SC_TRUNC) begin
         cut = $urandom_range(SHORT_LIMIT, int'(hdr) + int'(body_len) + 3);
         while (image_bytes.size() > cut) void'(image_bytes.pop_back());
      end else if (sc == SC_SHORT) begin
         cut = $urandom_range(1, SHORT_LIMIT - 1);
         while (image_bytes.size() > cut) void'(image_bytes.pop_back());
      end
   endtask

   task automatic send_image();
      foreach (image_bytes[i])
         send_byte(image_bytes[i], i == image_bytes.size() - 1, 1'b0, ST_FOUND);
      images_sent++;
   endtask

   initial begin : stimulus
      int phase;
      int target;
      int img_in_phase;
      int first_pass;
      image_case_type sc;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: single-byte and short images, walking-bit payload
      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].st);
         if (DIRECTED_ROWS[i].last) images_sent++;
      end

      first_pass = 0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            wait_for_drain();
            apply_setting(phase);
         end
         target = bytes_sent + BYTES_PER_PHASE;
         img_in_phase = 0;
         while (bytes_sent < target) begin
            no_idle = ($urandom_range(0, 4) == 0);
            // Walk every flavor once, then favor images that carry a key
            if (first_pass < SC_COUNT) begin
               sc = image_case_type'(first_pass);
               first_pass++;
            end else if ($urandom_range(0, 99) < 45) begin
               sc = ($urandom_range(0, 3) == 0) ? SC_KEY_AT_END : SC_KEY;
            end else begin
               sc = image_case_type'($urandom_range(0, SC_COUNT - 1));
            end
            if (phase == 2 && img_in_phase == 0) begin
               // Hold the result side while bytes stream at full rate
               sc = SC_KEY;
               no_idle = 1'b1;
               long_hold_pending = 1'b1;
            end
            if (phase == 3 && img_in_phase == 2) wait_for_drain();
            build_image(sc);
            send_image();
            img_in_phase++;
         end
      end

      wait_for_drain();
      $display("covered %0d images, %0d bytes, %0d register settings",
               images_sent, bytes_sent, settings_used);
      $display("checked %0d key beats and %0d verdicts, verdict codes seen %b",
               key_beats, verdicts, status_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("timeout with %0d beats outstanding", expected_beats.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
